[hdl/rps_pkg.sv]
// ----------------------------------------------------------------------------
// rps_pkg
// Shared constants, register codes and transaction types of the three-axis
// rate PID stabilizer.
// ----------------------------------------------------------------------------
package rps_pkg;

   localparam int AXIS_COUNT = 3;
   localparam int GAIN_REGS  = 3;
   localparam int DEADBAND   = 5;

   // front-to-back work queue
   localparam int WQ_DEPTH = 4;
   localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
   localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);

   // result queue
   localparam int RQ_DEPTH = 8;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   localparam int STICK_W = 13;
   localparam int ERR_W   = 17;
   localparam int DIFF_W  = 18;
   localparam int ADD_W   = 17;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [1:0] AXIS_ROLL  = 2'd0;
   localparam logic [1:0] AXIS_PITCH = 2'd1;

   localparam logic [1:0] CENTER_FIXED = 2'd1;
   localparam logic [1:0] CENTER_AUTO  = 2'd2;

   localparam logic [2:0] REG_ROLL_GAINS   = 3'd0;
   localparam logic [2:0] REG_PITCH_GAINS  = 3'd1;
   localparam logic [2:0] REG_YAW_GAINS    = 3'd2;
   localparam logic [2:0] REG_ROLL_LIMITS  = 3'd3;
   localparam logic [2:0] REG_PITCH_LIMITS = 3'd4;
   localparam logic [2:0] REG_YAW_LIMITS   = 3'd5;
   localparam logic [2:0] REG_MODE_BITS    = 3'd6;

   typedef struct packed {
      logic [3:0] shift;
      logic       unmix;
      logic [1:0] center;
   } mode_type;

   typedef struct packed {
      logic [1:0]              axis;
      logic                    stab;
      logic                    fix_clamp;
      logic                    decay;
      logic signed [ADD_W-1:0] add_value;
      logic signed [ERR_W-1:0] err;
      logic signed [15:0]      tilt;
      logic                    alev;
   } work_item_type;

   typedef struct packed {
      logic [1:0]         axis;
      logic signed [15:0] gyro_corr;
      logic signed [15:0] level_corr;
   } result_type;

   typedef logic [GAIN_REGS-1:0][31:0] gains_array_type;
   typedef logic [GAIN_REGS-1:0][47:0] limits_array_type;

endpackage

[hdl/rps_front.sv]
// ----------------------------------------------------------------------------
// rps_front
// Accepts axis samples, drops unused axes, conditions the stick and works out
// the error and the integrator step ahead of the back end.
// ----------------------------------------------------------------------------
module rps_front import rps_pkg::*; (
   input  logic               push,
   output logic               full,
   input  logic [1:0]         axis_sel,
   input  logic signed [15:0] gyro_rate,
   input  logic signed [11:0] stick_in,
   input  logic signed [11:0] flap_stick,
   input  logic signed [15:0] tilt_angle,
   input  logic               stability_on,
   input  logic               autolevel_on,
   input  mode_type           mode,
   input  logic               wq_full,
   output logic               wq_push,
   output work_item_type      item
);

   localparam logic signed [15:0] DB_HI = 16'(DEADBAND);
   localparam logic signed [15:0] DB_LO = -16'(DEADBAND);

   logic signed [STICK_W-1:0] stick_ext;
   logic signed [STICK_W-1:0] flap_ext;
   logic signed [STICK_W-1:0] mix_sum;
   logic signed [STICK_W-1:0] stick_c;
   logic signed [STICK_W-1:0] stick_sh;
   logic signed [STICK_W-1:0] stick_q;
   logic signed [ERR_W-1:0]   gyro_ext;
   logic signed [ERR_W-1:0]   sst_ext;
   logic                      big;
   logic                      fix_clamp;

   assign stick_ext = $signed({stick_in[11], stick_in});
   assign flap_ext  = $signed({flap_stick[11], flap_stick});
   assign mix_sum   = stick_ext + flap_ext;

   always_comb begin
      if (axis_sel == AXIS_PITCH) begin
         stick_c = -stick_ext;
      end else if (axis_sel == AXIS_ROLL && mode.unmix) begin
         stick_c = mix_sum >>> 1;
      end else begin
         stick_c = stick_ext;
      end
   end

   assign stick_sh  = stick_c >>> mode.shift;
   assign stick_q   = stick_c >>> 2;
   assign gyro_ext  = $signed({gyro_rate[15], gyro_rate});
   assign sst_ext   = $signed({{(ERR_W-STICK_W){stick_sh[STICK_W-1]}}, stick_sh});
   assign big       = (gyro_rate > DB_HI) || (gyro_rate < DB_LO);
   assign fix_clamp = (mode.center == CENTER_FIXED) && (stick_c != '0);

   always_comb begin
      item.axis      = axis_sel;
      item.stab      = stability_on;
      item.fix_clamp = fix_clamp;
      item.decay     = (mode.center == CENTER_AUTO) && !big;
      if (fix_clamp) begin
         item.add_value = big ? (gyro_ext - sst_ext) : -sst_ext;
      end else begin
         item.add_value = big ? gyro_ext : '0;
      end
      item.err  = gyro_ext - $signed({{(ERR_W-STICK_W){stick_q[STICK_W-1]}}, stick_q});
      item.tilt = tilt_angle;
      item.alev = autolevel_on && (axis_sel == AXIS_ROLL || axis_sel == AXIS_PITCH);
   end

   // unused axis: taken off the port, never queued
   assign full    = wq_full;
   assign wq_push = push && !wq_full && (axis_sel < 2'(AXIS_COUNT));

endmodule

[hdl/rps_work_queue.sv]
// ----------------------------------------------------------------------------
// rps_work_queue
// Short queue of conditioned samples between the front and the back end.
// ----------------------------------------------------------------------------
module rps_work_queue import rps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  work_item_type item_in,
   input  logic          pop,
   output work_item_type item_out,
   output logic          full,
   output logic          empty
);

   work_item_type       mem_ff [WQ_DEPTH];
   logic [WQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [WQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [WQ_CNT_W-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == WQ_CNT_W'(WQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/rps_back.sv]
// ----------------------------------------------------------------------------
// rps_back
// Per-axis integrator and last-error state, then a three-stage pipeline for
// the P, I, D and level terms. Takes work only when the result queue has room.
// ----------------------------------------------------------------------------
module rps_back import rps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                wq_empty,
   input  work_item_type       item,
   output logic                wq_pop,
   input  gains_array_type     gains,
   input  limits_array_type    limits,
   input  logic [RQ_CNT_W-1:0] rq_count,
   output logic                res_valid,
   output result_type          result
);

   // per-axis state
   logic signed [31:0]       integ_ff [AXIS_COUNT];
   logic signed [ERR_W-1:0]  prev_ff  [AXIS_COUNT];

   // stage 1: state update
   logic signed [31:0]       integ_cur;
   logic signed [31:0]       cmax_pos, cmax_neg;
   logic signed [31:0]       integ_clamp;
   logic signed [31:0]       integ_base;
   logic signed [ADD_W-1:0]  step;
   logic signed [31:0]       integ_new;
   logic signed [31:0]       integ_sel;
   logic signed [DIFF_W-1:0] diff;
   logic [RQ_CNT_W:0]        credit;
   logic                     take;

   logic                     s1_valid_ff;
   logic [1:0]               s1_axis_ff;
   logic signed [31:0]       s1_integ_ff;
   logic signed [ERR_W-1:0]  s1_err_ff;
   logic signed [DIFF_W-1:0] s1_diff_ff;
   logic signed [15:0]       s1_tilt_ff;
   logic                     s1_alev_ff;

   // stage 2: products
   logic [31:0]              g;
   logic signed [7:0]        pg, ig, dg, lg;
   logic signed [24:0]       p_prod;
   logic signed [39:0]       i_prod;
   logic signed [25:0]       d_prod;
   logic signed [23:0]       l_prod;

   logic                     s2_valid_ff;
   logic [1:0]               s2_axis_ff;
   logic signed [24:0]       s2_p_ff;
   logic signed [39:0]       s2_i_ff;
   logic signed [25:0]       s2_d_ff;
   logic signed [23:0]       s2_l_ff;

   // stage 3: scaling and I clamp
   logic signed [34:0]       i_shift;
   logic signed [34:0]       ilim_pos, ilim_neg;
   logic signed [34:0]       i_sel;
   logic signed [26:0]       p_ext;

   logic                     s3_valid_ff;
   logic [1:0]               s3_axis_ff;
   logic signed [26:0]       s3_p_ff;
   logic signed [24:0]       s3_i_ff;
   logic signed [29:0]       s3_d_ff;
   logic signed [15:0]       s3_l_ff;

   logic signed [31:0]       sum;

   // keep room in the result queue for everything in flight
   assign credit = {1'b0, rq_count} + (RQ_CNT_W+1)'(s1_valid_ff)
                 + (RQ_CNT_W+1)'(s2_valid_ff) + (RQ_CNT_W+1)'(s3_valid_ff);
   assign take   = !wq_empty && (credit < (RQ_CNT_W+1)'(RQ_DEPTH));
   assign wq_pop = take;

   assign integ_cur = integ_ff[item.axis];
   assign cmax_pos  = $signed({8'b0, limits[item.axis][23:0]});
   assign cmax_neg  = -cmax_pos;

   always_comb begin
      if (integ_cur > cmax_pos) begin
         integ_clamp = cmax_pos;
      end else if (integ_cur < cmax_neg) begin
         integ_clamp = cmax_neg;
      end else begin
         integ_clamp = integ_cur;
      end
      integ_base = item.fix_clamp ? integ_clamp : integ_cur;
      // auto centering: one count toward zero inside the deadband
      if (item.decay) begin
         if (integ_cur[31]) begin
            step = ADD_W'(1);
         end else if (integ_cur != '0) begin
            step = -ADD_W'(1);
         end else begin
            step = '0;
         end
      end else begin
         step = item.add_value;
      end
      integ_new = integ_base + $signed({{(32-ADD_W){step[ADD_W-1]}}, step});
      integ_sel = item.stab ? integ_new : integ_cur;
   end

   assign diff = $signed({item.err[ERR_W-1], item.err})
               - $signed({prev_ff[item.axis][ERR_W-1], prev_ff[item.axis]});

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXIS_COUNT; a++) begin
            integ_ff[a] <= '0;
            prev_ff[a]  <= '0;
         end
      end else if (take) begin
         if (item.stab) begin
            integ_ff[item.axis] <= integ_new;
         end
         prev_ff[item.axis] <= item.err;
      end
   end

   always_ff @(posedge clock) begin
      s1_axis_ff  <= item.axis;
      s1_integ_ff <= integ_sel;
      s1_err_ff   <= item.err;
      s1_diff_ff  <= diff;
      s1_tilt_ff  <= item.tilt;
      s1_alev_ff  <= item.alev;
   end

   assign g  = gains[s1_axis_ff];
   assign pg = $signed(g[7:0]);
   assign ig = $signed(g[15:8]);
   assign dg = $signed(g[23:16]);
   assign lg = $signed(g[31:24]);

   assign p_prod = s1_err_ff * pg;
   assign i_prod = s1_integ_ff * ig;
   assign d_prod = s1_diff_ff * dg;
   // both arms signed so the product is formed signed
   assign l_prod = s1_alev_ff ? s1_tilt_ff * lg : 24'sd0;

   always_ff @(posedge clock) begin
      s2_axis_ff <= s1_axis_ff;
      s2_p_ff    <= p_prod;
      s2_i_ff    <= i_prod;
      s2_d_ff    <= d_prod;
      s2_l_ff    <= l_prod;
   end

   assign i_shift  = $signed(s2_i_ff[39:5]);
   assign ilim_pos = $signed({11'b0, limits[s2_axis_ff][47:24]});
   assign ilim_neg = -ilim_pos;
   assign p_ext    = $signed({{2{s2_p_ff[24]}}, s2_p_ff});

   always_comb begin
      if (i_shift > ilim_pos) begin
         i_sel = ilim_pos;
      end else if (i_shift < ilim_neg) begin
         i_sel = ilim_neg;
      end else begin
         i_sel = i_shift;
      end
   end

   always_ff @(posedge clock) begin
      s3_axis_ff <= s2_axis_ff;
      s3_p_ff    <= p_ext + (p_ext <<< 1);
      s3_i_ff    <= i_sel[24:0];
      s3_d_ff    <= $signed({s2_d_ff, 4'b0});
      s3_l_ff    <= s2_l_ff[17:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= take;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   assign sum = $signed({{5{s3_p_ff[26]}}, s3_p_ff}) + $signed({{7{s3_i_ff[24]}}, s3_i_ff})
              + $signed({{2{s3_d_ff[29]}}, s3_d_ff});

   assign res_valid         = s3_valid_ff;
   assign result.axis       = s3_axis_ff;
   assign result.gyro_corr  = sum[21:6];
   assign result.level_corr = s3_l_ff;

endmodule

[hdl/rps_result_queue.sv]
// ----------------------------------------------------------------------------
// rps_result_queue
// Output queue of finished results; its fill count gives the back end credit.
// ----------------------------------------------------------------------------
module rps_result_queue import rps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  result_type          data_in,
   input  logic                pop,
   output result_type          data_out,
   output logic                empty,
   output logic [RQ_CNT_W-1:0] count
);

   result_type          mem_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0] count_ff, count_in;
   logic                do_pop;

   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/three_axis_rate_pid_stabilizer.sv]
// ----------------------------------------------------------------------------
// three_axis_rate_pid_stabilizer
// A sample passes the work queue, the back-end pipeline and the result queue before its result is on the rsp ports.
// Throughput: one sample per cycle while the work queue is not full and the result queue has room.
// Samples for axis 3 are dropped and give no result.
// Reset clears the registers, the integrators, the last errors and both queues.
// ----------------------------------------------------------------------------
module three_axis_rate_pid_stabilizer import rps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // sample queue
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_axis_sel,
   input  logic signed [15:0]    req_gyro_rate,
   input  logic signed [11:0]    req_stick_in,
   input  logic signed [11:0]    req_flap_stick,
   input  logic signed [15:0]    req_tilt_angle,
   input  logic                  req_stability_on,
   input  logic                  req_autolevel_on,
   // result queue
   input  logic                  pop,
   output logic                  empty,
   output logic [1:0]            rsp_axis_out,
   output logic signed [15:0]    rsp_gyro_correction,
   output logic signed [15:0]    rsp_level_correction,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   gains_array_type     gains_ff;
   limits_array_type    limits_ff;
   logic [6:0]          mode_ff;
   logic [2:0]          reg_index;
   logic                csr_write;

   work_item_type       front_item;
   work_item_type       wq_item;
   logic                wq_push;
   logic                wq_pop;
   logic                wq_full;
   logic                wq_empty;

   logic                rq_push;
   result_type          rq_data_in;
   result_type          rq_data_out;
   logic [RQ_CNT_W-1:0] rq_count;

   // register file
   assign pready    = 1'b1;
   assign reg_index = paddr[5:3];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff  <= '0;
         limits_ff <= '0;
         mode_ff   <= '0;
      end else if (csr_write) begin
         case (reg_index)
            REG_ROLL_GAINS:   gains_ff[0]  <= pwdata[31:0];
            REG_PITCH_GAINS:  gains_ff[1]  <= pwdata[31:0];
            REG_YAW_GAINS:    gains_ff[2]  <= pwdata[31:0];
            REG_ROLL_LIMITS:  limits_ff[0] <= pwdata[47:0];
            REG_PITCH_LIMITS: limits_ff[1] <= pwdata[47:0];
            REG_YAW_LIMITS:   limits_ff[2] <= pwdata[47:0];
            REG_MODE_BITS:    mode_ff      <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ROLL_GAINS:   prdata = {32'b0, gains_ff[0]};
         REG_PITCH_GAINS:  prdata = {32'b0, gains_ff[1]};
         REG_YAW_GAINS:    prdata = {32'b0, gains_ff[2]};
         REG_ROLL_LIMITS:  prdata = {16'b0, limits_ff[0]};
         REG_PITCH_LIMITS: prdata = {16'b0, limits_ff[1]};
         REG_YAW_LIMITS:   prdata = {16'b0, limits_ff[2]};
         REG_MODE_BITS:    prdata = {57'b0, mode_ff};
         default:          prdata = '0;
      endcase
   end

   rps_front u_front (
      .push         (push),
      .full         (full),
      .axis_sel     (req_axis_sel),
      .gyro_rate    (req_gyro_rate),
      .stick_in     (req_stick_in),
      .flap_stick   (req_flap_stick),
      .tilt_angle   (req_tilt_angle),
      .stability_on (req_stability_on),
      .autolevel_on (req_autolevel_on),
      .mode         (mode_type'(mode_ff)),
      .wq_full      (wq_full),
      .wq_push      (wq_push),
      .item         (front_item)
   );

   rps_work_queue u_work_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (wq_push),
      .item_in  (front_item),
      .pop      (wq_pop),
      .item_out (wq_item),
      .full     (wq_full),
      .empty    (wq_empty)
   );

   rps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .wq_empty  (wq_empty),
      .item      (wq_item),
      .wq_pop    (wq_pop),
      .gains     (gains_ff),
      .limits    (limits_ff),
      .rq_count  (rq_count),
      .res_valid (rq_push),
      .result    (rq_data_in)
   );

   rps_result_queue u_result_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rq_push),
      .data_in  (rq_data_in),
      .pop      (pop),
      .data_out (rq_data_out),
      .empty    (empty),
      .count    (rq_count)
   );

   assign rsp_axis_out         = rq_data_out.axis;
   assign rsp_gyro_correction  = rq_data_out.gyro_corr;
   assign rsp_level_correction = rq_data_out.level_corr;

   // credit scheme must never let a result land in a full queue
   assert property (@(posedge clock) disable iff (reset)
      rq_push |-> (rq_count < RQ_CNT_W'(RQ_DEPTH)))
      else $error("result queue overflow");

   // every transaction the back end takes comes out of the pipeline as a result
   assert property (@(posedge clock) disable iff (reset)
      wq_pop |-> ##3 rq_push)
      else $error("back end lost a transaction");

   // a finished result is visible on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      rq_push |=> !empty)
      else $error("result not visible after write");

   // unused axis must never reach the work queue
   assert property (@(posedge clock) disable iff (reset)
      wq_push |-> (req_axis_sel < 2'(AXIS_COUNT)))
      else $error("unused axis queued");

endmodule

[verif/rate_pid_checker.sv]
// ----------------------------------------------------------------------------
// rate_pid_checker
// Watches the sample, result and register ports of the rate PID stabilizer.
// It keeps its own copy of the registers, integrators and last errors. From
// that it predicts the correction for every accepted sample of a used axis,
// and it compares each popped result with the oldest prediction.
// ----------------------------------------------------------------------------
module rate_pid_checker import rps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  logic [1:0]            req_axis_sel,
   input  logic signed [15:0]    req_gyro_rate,
   input  logic signed [11:0]    req_stick_in,
   input  logic signed [11:0]    req_flap_stick,
   input  logic signed [15:0]    req_tilt_angle,
   input  logic                  req_stability_on,
   input  logic                  req_autolevel_on,
   input  logic                  pop,
   input  logic                  empty,
   input  logic [1:0]            rsp_axis_out,
   input  logic signed [15:0]    rsp_gyro_correction,
   input  logic signed [15:0]    rsp_level_correction,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    mismatches,
   output int                    outstanding,
   output int                    checked
);

   localparam int MAX_REPORTS = 10;

   gains_array_type  gains_q;
   limits_array_type limits_q;
   mode_type         mode_q;
   logic [2:0][31:0] integ_q;
   logic [2:0][31:0] last_err_q;
   result_type       correction_queue[$];

   function automatic result_type stabilize_sample(
      input logic [1:0]         ax,
      input logic signed [15:0] gyro_in,
      input logic signed [11:0] stick_raw,
      input logic signed [11:0] flap_in,
      input logic signed [15:0] tilt_in,
      input logic               stab,
      input logic               alev
   );
      longint     gyro, stick, err, integ, sum, lev;
      longint     p_term, i_term, d_term;
      longint     p_gain, i_gain, d_gain, l_gain, clamp_max, i_limit;
      result_type r;
      p_gain    = $signed(gains_q[ax][7:0]);
      i_gain    = $signed(gains_q[ax][15:8]);
      d_gain    = $signed(gains_q[ax][23:16]);
      l_gain    = $signed(gains_q[ax][31:24]);
      clamp_max = limits_q[ax][23:0];
      i_limit   = limits_q[ax][47:24];
      gyro      = gyro_in;
      stick     = stick_raw;

      if (ax == AXIS_PITCH)
         stick = -stick;
      else if (ax == AXIS_ROLL && mode_q.unmix)
         stick = (stick + flap_in) >>> 1;

      if (stab) begin
         integ = $signed(integ_q[ax]);
         // fixed centering: clamp first, then back off by the shifted stick
         if (mode_q.center == CENTER_FIXED && stick != 0) begin
            if (integ > clamp_max)
               integ = clamp_max;
            if (integ < -clamp_max)
               integ = -clamp_max;
            integ -= stick >>> mode_q.shift;
         end
         if (gyro > DEADBAND || gyro < -DEADBAND) begin
            integ += gyro;
         end else if (mode_q.center == CENTER_AUTO) begin
            if (integ > 0)
               integ--;
            else if (integ < 0)
               integ++;
         end
         integ_q[ax] = integ[31:0];
      end

      err    = gyro - (stick >>> 2);
      p_term = err * p_gain * 3;
      i_term = ($signed(integ_q[ax]) * i_gain) >>> 5;
      if (i_term > i_limit)
         i_term = i_limit;
      else if (i_term < -i_limit)
         i_term = -i_limit;
      d_term = (err - $signed(last_err_q[ax])) * d_gain * 16;
      last_err_q[ax] = err[31:0];
      sum = (p_term + i_term + d_term) >>> 6;

      if (alev && ax <= AXIS_PITCH)
         lev = (tilt_in * l_gain) >>> 2;
      else
         lev = 0;

      r.axis       = ax;
      r.gyro_corr  = sum[15:0];
      r.level_corr = lev[15:0];
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      result_type seen, want;
      if (reset) begin
         gains_q    = '0;
         limits_q   = '0;
         mode_q     = '0;
         integ_q    = '0;
         last_err_q = '0;
         correction_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
               REG_ROLL_GAINS:   gains_q[0]  = pwdata[31:0];
               REG_PITCH_GAINS:  gains_q[1]  = pwdata[31:0];
               REG_YAW_GAINS:    gains_q[2]  = pwdata[31:0];
               REG_ROLL_LIMITS:  limits_q[0] = pwdata[47:0];
               REG_PITCH_LIMITS: limits_q[1] = pwdata[47:0];
               REG_YAW_LIMITS:   limits_q[2] = pwdata[47:0];
               REG_MODE_BITS:    mode_q      = pwdata[6:0];
               default: ;
            endcase
         end

         // results first: a sample taken at this edge cannot be popped at it
         if (pop && !empty) begin
            seen.axis       = rsp_axis_out;
            seen.gyro_corr  = rsp_gyro_correction;
            seen.level_corr = rsp_level_correction;
            if (correction_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result transaction: axis %0d gyro %0d level %0d",
                           seen.axis, $signed(seen.gyro_corr), $signed(seen.level_corr));
            end else begin
               want = correction_queue.pop_front();
               checked++;
               if (seen.axis !== want.axis || seen.gyro_corr !== want.gyro_corr ||
                   seen.level_corr !== want.level_corr) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: axis %0d/%0d gyro_correction %0d/%0d level_correction %0d/%0d (expected/actual)",
                              want.axis, seen.axis,
                              $signed(want.gyro_corr), $signed(seen.gyro_corr),
                              $signed(want.level_corr), $signed(seen.level_corr));
               end
            end
         end

         if (push && !full && req_axis_sel < AXIS_COUNT)
            correction_queue.push_back(stabilize_sample(req_axis_sel, req_gyro_rate,
               req_stick_in, req_flap_stick, req_tilt_angle, req_stability_on,
               req_autolevel_on));
      end
      outstanding = correction_queue.size();
   end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the three-axis rate PID stabilizer. A short directed part covers
// the field extremes, the deadband edges, every centering mode and the unused
// axis. It is followed by random samples under several register settings, with
// random gaps on both queues, a gap-free stretch and a long result hold-off.
// Checking is done by rate_pid_checker.
// ----------------------------------------------------------------------------
module testbench;
   import rps_pkg::*;

   localparam int PHASE_ITEMS    = 250;
   localparam int RANDOM_PHASES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int AXIS_YAW       = 2;
   localparam int AXIS_UNUSED    = 3;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  push             = 1'b0;
   logic [1:0]            req_axis_sel     = '0;
   logic signed [15:0]    req_gyro_rate    = '0;
   logic signed [11:0]    req_stick_in     = '0;
   logic signed [11:0]    req_flap_stick   = '0;
   logic signed [15:0]    req_tilt_angle   = '0;
   logic                  req_stability_on = 1'b0;
   logic                  req_autolevel_on = 1'b0;
   logic                  pop              = 1'b0;
   logic                  psel             = 1'b0;
   logic                  penable          = 1'b0;
   logic                  pwrite           = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr            = '0;
   logic [CSR_DATA_W-1:0] pwdata           = '0;
   logic                  full, empty, pready;
   logic [1:0]            rsp_axis_out;
   logic signed [15:0]    rsp_gyro_correction, rsp_level_correction;
   logic [CSR_DATA_W-1:0] prdata;
   int                    mismatches, outstanding, checked;

   int idle_cycles   = 0;
   int sent_count    = 0;
   int dropped_count = 0;
   int write_count   = 0;
   bit gaps_on       = 1'b1;
   bit hold_request  = 1'b0;

   three_axis_rate_pid_stabilizer u_dut (.*);

   rate_pid_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // caller stands at a falling edge; returns at the falling edge after acceptance
   task automatic send_sample(input int axis, gyro, stick, flap, tilt, stab, alev);
      while (gaps_on && $urandom_range(99) < 33) begin
         push = 1'b0;
         @(negedge clock);
      end
      push             = 1'b1;
      req_axis_sel     = 2'(axis);
      req_gyro_rate    = 16'(gyro);
      req_stick_in     = 12'(stick);
      req_flap_stick   = 12'(flap);
      req_tilt_angle   = 16'(tilt);
      req_stability_on = 1'(stab);
      req_autolevel_on = 1'(alev);
      @(posedge clock);
      while (full)
         @(posedge clock);
      @(negedge clock);
      sent_count++;
      if (axis == AXIS_UNUSED)
         dropped_count++;
   endtask

   task automatic send_random();
      int gyro, stick;
      case ($urandom_range(2))
         0:       gyro = $urandom_range(16) - 8;
         1:       gyro = $urandom_range(600) - 300;
         default: gyro = $urandom_range(65535) - 32768;
      endcase
      case ($urandom_range(2))
         0:       stick = 0;
         1:       stick = $urandom_range(16) - 8;
         default: stick = $urandom_range(4095) - 2048;
      endcase
      send_sample(($urandom_range(99) < 4) ? AXIS_UNUSED : $urandom_range(2), gyro, stick,
                  $urandom_range(4095) - 2048, $urandom_range(65535) - 32768,
                  $urandom_range(9) != 0, $urandom_range(1));
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [CSR_DATA_W-1:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 3'b000};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      write_count++;
   endtask

   task automatic load_settings(input logic [31:0] roll_g, pitch_g, yaw_g,
                                input logic [47:0] roll_l, pitch_l, yaw_l,
                                input logic [6:0] mode);
      write_reg(REG_ROLL_GAINS, roll_g);
      write_reg(REG_PITCH_GAINS, pitch_g);
      write_reg(REG_YAW_GAINS, yaw_g);
      write_reg(REG_ROLL_LIMITS, roll_l);
      write_reg(REG_PITCH_LIMITS, pitch_l);
      write_reg(REG_YAW_LIMITS, yaw_l);
      write_reg(REG_MODE_BITS, mode);
   endtask

   function automatic logic [47:0] pick_limits(input bit narrow);
      if (narrow)
         return {24'($urandom_range(3000)), 24'($urandom_range(3000))};
      return {16'($urandom), 32'($urandom)};
   endfunction

   // dropped samples give no result, so give the pipeline time to empty
   task automatic settle();
      push = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES)
         @(negedge clock);
   endtask

   // result side
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            pop = 1'b0;
            for (int n = 1; n < HOLD_CYCLES; n++)
               @(negedge clock);
         end else begin
            pop = !gaps_on || $urandom_range(99) >= 33;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (push && !full) || (pop && !empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int target;
      repeat (6)
         @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fixed centering with flaperon unmix, extreme gain bytes
      load_settings(32'h807F807F, 32'h7F807F80, 32'hFFFFFFFF,
                    {24'd50, 24'd100}, '1, '0, {4'd3, 1'b1, CENTER_FIXED});
      send_sample(AXIS_ROLL, 32767, 2047, 2047, 32767, 1, 1);
      send_sample(AXIS_ROLL, -32768, -2048, -2048, -32768, 1, 1);
      send_sample(AXIS_PITCH, 5, 0, 0, 1000, 1, 1);
      send_sample(AXIS_PITCH, 6, -2048, 0, -1000, 1, 1);
      send_sample(AXIS_YAW, -5, 2047, 0, 32767, 1, 1);
      send_sample(AXIS_YAW, -6, 0, 0, 0, 0, 0);
      send_sample(AXIS_UNUSED, 1000, 100, 0, 500, 1, 1);
      send_sample(AXIS_ROLL, 0, 100, -100, 0, 1, 0);
      settle();

      // auto centering: samples inside the deadband pull the integrator back
      write_reg(REG_MODE_BITS, {4'd0, 1'b0, CENTER_AUTO});
      send_sample(AXIS_ROLL, 3, 0, 0, 0, 1, 0);
      send_sample(AXIS_ROLL, -5, 0, 0, 0, 1, 0);
      send_sample(AXIS_PITCH, 4, 0, 0, 0, 1, 1);
      send_sample(AXIS_PITCH, 4, 0, 0, 0, 0, 1);
      send_sample(AXIS_YAW, 0, 0, 0, 0, 1, 0);
      send_sample(AXIS_YAW, 5, 0, 0, 0, 1, 0);
      send_sample(AXIS_ROLL, 7, 0, 0, -32768, 1, 0);
      settle();

      // center mode three behaves as none
      write_reg(REG_MODE_BITS, 7'h7F);
      send_sample(AXIS_ROLL, 2, 500, 1, 0, 1, 1);
      send_sample(AXIS_PITCH, -3, 7, 0, 0, 1, 1);
      send_sample(AXIS_YAW, 10, 0, 0, 0, 1, 0);
      settle();

      // zero clamp, largest stick shift
      write_reg(REG_ROLL_LIMITS, '0);
      write_reg(REG_MODE_BITS, {4'd15, 1'b0, CENTER_FIXED});
      send_sample(AXIS_ROLL, 20000, -1, 0, 0, 1, 0);
      send_sample(AXIS_ROLL, -20000, 1, 0, 0, 1, 0);
      send_sample(AXIS_PITCH, 3, 5, 0, 0, 1, 0);
      send_sample(AXIS_YAW, 0, 0, 0, 0, 1, 0);
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: load_settings(32'h7F7F7F7F, 32'h7F7F7F7F, 32'h7F7F7F7F, '1, '1, '1,
                             {4'd15, 1'b1, CENTER_FIXED});
            1: load_settings('0, '0, '0, '0, '0, '0, '0);
            2: load_settings(32'h80808080, 32'h80808080, 32'h80808080, '1, '1, '1,
                             {4'd0, 1'b0, CENTER_AUTO});
            default: load_settings($urandom, $urandom, $urandom, pick_limits(phase[0]),
                                   pick_limits(phase[0]), pick_limits(phase[0]),
                                   {4'($urandom), 1'($urandom), 2'(phase)});
         endcase
         gaps_on = (phase != 1);
         if (phase == 2)
            hold_request = 1'b1;
         target = sent_count - dropped_count + PHASE_ITEMS;
         while (sent_count - dropped_count < target)
            send_random();
         settle();
      end

      $display("Sent %0d samples (%0d on the unused axis), checked %0d results, %0d register writes.",
               sent_count, dropped_count, checked, write_count);
      $display("Covered all centering modes, a gap-free stretch and a %0d-cycle result hold-off.",
               HOLD_CYCLES);
      if (mismatches == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
